@@ sv/ps2_set1_scancode_to_ascii_defines.svh @@
// Assertion macros used by the checker file of the scancode decoder
`ifndef PS2_SET1_SCANCODE_TO_ASCII_DEFINES_SVH
`define PS2_SET1_SCANCODE_TO_ASCII_DEFINES_SVH

// General clocked property with asynchronous active-low reset
`define PS2S1_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// A signal holds its value in the cycle after a condition
`define PS2S1_ASSERT_HOLD(lbl, clk, rst_n, cond, sig, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> $stable(sig)) \
        else $error(msg);

`endif

@@ sv/ps2s1_pkg.sv @@
// Shared types, codes and character tables of the set-1 scancode decoder
package ps2s1_pkg;

    localparam int unsigned CodeW   = 8;
    localparam int unsigned RegIdxW = 3;
    localparam int unsigned TableLen = 58;
    localparam int unsigned RomDepth = 64;

    // transaction kinds on the item channel
    localparam logic KindScan = 1'b0;
    localparam logic KindRead = 1'b1;

    // configuration register indices
    localparam logic [RegIdxW-1:0] RegArrowUp    = 3'd0;
    localparam logic [RegIdxW-1:0] RegArrowDown  = 3'd1;
    localparam logic [RegIdxW-1:0] RegArrowLeft  = 3'd2;
    localparam logic [RegIdxW-1:0] RegArrowRight = 3'd3;
    localparam logic [RegIdxW-1:0] RegBreak      = 3'd4;

    // scancodes
    localparam logic [CodeW-1:0] ScExtPrefix  = 8'hE0;
    localparam logic [CodeW-1:0] ScCtrlMake   = 8'h1D;
    localparam logic [CodeW-1:0] ScCtrlBreak  = 8'h9D;
    localparam logic [CodeW-1:0] ScLShiftMake = 8'h2A;
    localparam logic [CodeW-1:0] ScRShiftMake = 8'h36;
    localparam logic [CodeW-1:0] ScLShiftBrk  = 8'hAA;
    localparam logic [CodeW-1:0] ScRShiftBrk  = 8'hB6;
    localparam logic [CodeW-1:0] ScKeyC       = 8'h2E;
    localparam logic [CodeW-1:0] ScUp         = 8'h48;
    localparam logic [CodeW-1:0] ScDown       = 8'h50;
    localparam logic [CodeW-1:0] ScLeft       = 8'h4B;
    localparam logic [CodeW-1:0] ScRight      = 8'h4D;

    localparam logic [CodeW-1:0] ChBackspace = 8'h08;
    localparam logic [CodeW-1:0] ChNewline   = 8'h0A;
    localparam logic [CodeW-1:0] ChFirstPrt  = 8'h20;
    localparam logic [CodeW-1:0] ChLastPrt   = 8'h7E;

    typedef struct packed {
        logic             shift_held;
        logic             ctrl_held;
        logic             prefix_seen;
        logic [CodeW-1:0] held_char;
    } state_t;

    typedef struct packed {
        logic [CodeW-1:0] arrow_up_code;
        logic [CodeW-1:0] arrow_down_code;
        logic [CodeW-1:0] arrow_left_code;
        logic [CodeW-1:0] arrow_right_code;
        logic [CodeW-1:0] break_code;
    } cfg_t;

    // padded to 64; entries past the table are zero
    localparam logic [CodeW-1:0] PlainRom [RomDepth] = '{
        8'h00, 8'h00, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
        8'h37, 8'h38, 8'h39, 8'h30, 8'h2D, 8'h3D, 8'h08, 8'h00,
        8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h75, 8'h69,
        8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0A, 8'h00, 8'h61, 8'h73,
        8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3B,
        8'h27, 8'h60, 8'h00, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76,
        8'h62, 8'h6E, 8'h6D, 8'h2C, 8'h2E, 8'h2F, 8'h00, 8'h2A,
        8'h00, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
    };

    localparam logic [CodeW-1:0] ShiftRom [RomDepth] = '{
        8'h00, 8'h00, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E,
        8'h26, 8'h2A, 8'h28, 8'h29, 8'h5F, 8'h2B, 8'h00, 8'h00,
        8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
        8'h4F, 8'h50, 8'h7B, 8'h7D, 8'h0A, 8'h00, 8'h41, 8'h53,
        8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h3A,
        8'h22, 8'h7E, 8'h00, 8'h7C, 8'h5A, 8'h58, 8'h43, 8'h56,
        8'h42, 8'h4E, 8'h4D, 8'h3C, 8'h3E, 8'h3F, 8'h00, 8'h2A,
        8'h00, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
    };

endpackage

@@ sv/ps2s1_item_if.sv @@
// Item channel: scancode byte or read request
interface ps2s1_item_if;
    logic                         valid;
    logic                         ready;
    logic                         kind;
    logic [ps2s1_pkg::CodeW-1:0]  scan_byte;

    modport source (output valid, output kind, output scan_byte, input ready);
    modport sink   (input valid, input kind, input scan_byte, output ready);
endinterface

@@ sv/ps2s1_char_if.sv @@
// Result channel: character returned by a read
interface ps2s1_char_if;
    logic                         valid;
    logic                         ready;
    logic [ps2s1_pkg::CodeW-1:0]  char_out;

    modport source (output valid, output char_out, input ready);
    modport sink   (input valid, input char_out, output ready);
endinterface

@@ sv/ps2s1_cfg_if.sv @@
// Configuration write channel
interface ps2s1_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [ps2s1_pkg::RegIdxW-1:0] index;
    logic [ps2s1_pkg::CodeW-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ sv/ps2s1_state_ram.sv @@
// Single-entry synchronous state memory, write-first on a same-edge read
module ps2s1_state_ram (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              rd_en,
    input  logic              wr_en,
    input  ps2s1_pkg::state_t wr_data,
    output ps2s1_pkg::state_t rd_data
);

    ps2s1_pkg::state_t mem [1];
    ps2s1_pkg::state_t rd_data_reg;
    logic              written_reg;

    // entry reads as reset state until first written
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg <= 1'b0;
        end
        else if (wr_en)
        begin
            written_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[0] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            if (wr_en)
            begin
                rd_data_reg <= wr_data;
            end
            else if (written_reg)
            begin
                rd_data_reg <= mem[0];
            end
            else
            begin
                rd_data_reg <= '0;
            end
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ sv/ps2s1_decode.sv @@
// Next-state logic: read clear, modifier flags, E0 prefix, arrows, ctrl-C and table lookup
module ps2s1_decode (
    input  ps2s1_pkg::state_t                cur,
    input  logic                             kind,
    input  logic [ps2s1_pkg::CodeW-1:0]      scan_byte,
    input  ps2s1_pkg::cfg_t                  cfg,
    output ps2s1_pkg::state_t                nxt,
    output logic [ps2s1_pkg::CodeW-1:0]      char_out
);

    logic [ps2s1_pkg::CodeW-1:0] rom_char;
    logic                        keepable;

    always_comb
    begin
        rom_char = cur.shift_held ? ps2s1_pkg::ShiftRom[scan_byte[5:0]]
                                  : ps2s1_pkg::PlainRom[scan_byte[5:0]];
        keepable = ((rom_char >= ps2s1_pkg::ChFirstPrt) && (rom_char <= ps2s1_pkg::ChLastPrt))
                   || (rom_char == ps2s1_pkg::ChBackspace)
                   || (rom_char == ps2s1_pkg::ChNewline);
    end

    always_comb
    begin
        nxt      = cur;
        char_out = cur.held_char;
        if (kind == ps2s1_pkg::KindRead)
        begin
            nxt.held_char = '0;
        end
        else if (scan_byte == ps2s1_pkg::ScExtPrefix)
        begin
            nxt.prefix_seen = 1'b1;
        end
        else if (scan_byte == ps2s1_pkg::ScCtrlMake)
        begin
            nxt.ctrl_held = 1'b1;
        end
        else if (scan_byte == ps2s1_pkg::ScCtrlBreak)
        begin
            nxt.ctrl_held = 1'b0;
        end
        else if ((scan_byte == ps2s1_pkg::ScLShiftMake) ||
                 (scan_byte == ps2s1_pkg::ScRShiftMake))
        begin
            nxt.shift_held = 1'b1;
        end
        else if ((scan_byte == ps2s1_pkg::ScLShiftBrk) ||
                 (scan_byte == ps2s1_pkg::ScRShiftBrk))
        begin
            nxt.shift_held = 1'b0;
        end
        else if (cur.prefix_seen)
        begin
            // byte after E0: only the four arrow makes latch anything
            nxt.prefix_seen = 1'b0;
            if (scan_byte == ps2s1_pkg::ScUp)
            begin
                nxt.held_char = cfg.arrow_up_code;
            end
            else if (scan_byte == ps2s1_pkg::ScDown)
            begin
                nxt.held_char = cfg.arrow_down_code;
            end
            else if (scan_byte == ps2s1_pkg::ScLeft)
            begin
                nxt.held_char = cfg.arrow_left_code;
            end
            else if (scan_byte == ps2s1_pkg::ScRight)
            begin
                nxt.held_char = cfg.arrow_right_code;
            end
        end
        else if (!scan_byte[ps2s1_pkg::CodeW-1])
        begin
            if (cur.ctrl_held && (scan_byte == ps2s1_pkg::ScKeyC))
            begin
                nxt.held_char = cfg.break_code;
            end
            else if ((scan_byte < ps2s1_pkg::CodeW'(ps2s1_pkg::TableLen)) && keepable)
            begin
                nxt.held_char = rom_char;
            end
        end
    end

endmodule

@@ sv/ps2_set1_scancode_to_ascii.sv @@
// Top level of the set-1 scancode to character decoder
// Takes one transaction per clock on the item channel unless the decode stage
// stalls. Each item reads the decoder state from a one-entry synchronous memory
// at acceptance, is decoded in the following cycle and writes the state back
// as it leaves that stage; a same-edge read picks up the write, so consecutive
// items see each other's updates. A read's character is loaded into the result
// register as the read leaves the decode stage and is held until taken. The
// only stall is a read reaching the decode stage while the result register
// still holds an untaken character. Configuration writes are always taken.
module ps2_set1_scancode_to_ascii (
    input  logic    clk,
    input  logic    rst_n,
    ps2s1_item_if.sink   item,
    ps2s1_char_if.source result,
    ps2s1_cfg_if.sink    cfg
);

    ps2s1_pkg::cfg_t             cfg_reg, cfg_next;
    logic                        s1_valid_reg, s1_valid_next;
    logic                        s1_kind_reg;
    logic [ps2s1_pkg::CodeW-1:0] s1_byte_reg;
    logic                        out_valid_reg, out_valid_next;
    logic [ps2s1_pkg::CodeW-1:0] out_char_reg;

    ps2s1_pkg::state_t           cur_state;
    ps2s1_pkg::state_t           nxt_state;
    logic [ps2s1_pkg::CodeW-1:0] dec_char;
    logic                        out_free;
    logic                        s1_go;
    logic                        accept;

    assign out_free = !out_valid_reg || result.ready;
    assign s1_go    = s1_valid_reg && ((s1_kind_reg == ps2s1_pkg::KindScan) || out_free);
    assign item.ready = !s1_valid_reg || s1_go;
    assign accept   = item.valid && item.ready;

    assign cfg.ready = 1'b1;

    ps2s1_state_ram u_state_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept),
        .wr_en   (s1_go),
        .wr_data (nxt_state),
        .rd_data (cur_state)
    );

    ps2s1_decode u_decode (
        .cur       (cur_state),
        .kind      (s1_kind_reg),
        .scan_byte (s1_byte_reg),
        .cfg       (cfg_reg),
        .nxt       (nxt_state),
        .char_out  (dec_char)
    );

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            unique case (cfg.index)
                ps2s1_pkg::RegArrowUp:    cfg_next.arrow_up_code    = cfg.data;
                ps2s1_pkg::RegArrowDown:  cfg_next.arrow_down_code  = cfg.data;
                ps2s1_pkg::RegArrowLeft:  cfg_next.arrow_left_code  = cfg.data;
                ps2s1_pkg::RegArrowRight: cfg_next.arrow_right_code = cfg.data;
                ps2s1_pkg::RegBreak:      cfg_next.break_code       = cfg.data;
                default:                  cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_go)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end

        if (s1_go && (s1_kind_reg == ps2s1_pkg::KindRead))
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.arrow_up_code    <= 8'd128;
            cfg_reg.arrow_down_code  <= 8'd129;
            cfg_reg.arrow_left_code  <= 8'd130;
            cfg_reg.arrow_right_code <= 8'd131;
            cfg_reg.break_code       <= 8'd3;
            s1_valid_reg             <= 1'b0;
            out_valid_reg            <= 1'b0;
        end
        else
        begin
            cfg_reg       <= cfg_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_kind_reg <= item.kind;
            s1_byte_reg <= item.scan_byte;
        end
        if (s1_go && (s1_kind_reg == ps2s1_pkg::KindRead))
        begin
            out_char_reg <= dec_char;
        end
    end

    assign result.valid    = out_valid_reg;
    assign result.char_out = out_char_reg;

endmodule

@@ sv/ps2s1_checker.sv @@
// Port-level checks of the scancode decoder and their binding to the top level
`include "ps2_set1_scancode_to_ascii_defines.svh"

module ps2s1_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        item_valid,
    input logic                        item_ready,
    input logic                        item_kind,
    input logic                        result_valid,
    input logic                        result_ready,
    input logic [ps2s1_pkg::CodeW-1:0] result_char,
    input logic                        cfg_ready
);

    // a held result keeps its character
    `PS2S1_ASSERT_HOLD(a_result_hold, clk, rst_n, result_valid && !result_ready, result_char, "result changed while stalled")

    // a fresh result always stems from an accepted read
    `PS2S1_ASSERT(a_result_source, clk, rst_n, $rose(result_valid) |-> $past(item_valid && item_ready && (item_kind == ps2s1_pkg::KindRead), 2), "result without a read")

    // the item side only stalls behind an untaken result
    `PS2S1_ASSERT(a_stall_cause, clk, rst_n, !item_ready |-> (result_valid && !result_ready), "item stalled without backpressure")

    `PS2S1_ASSERT(a_cfg_ready, clk, rst_n, cfg_ready, "configuration port not ready")

endmodule

bind ps2_set1_scancode_to_ascii ps2s1_checker u_ps2s1_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item.valid),
    .item_ready   (item.ready),
    .item_kind    (item.kind),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .result_char  (result.char_out),
    .cfg_ready    (cfg.ready)
);
